@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: explicit clock and active-low reset
`define BSA_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// default clock and reset of this project
`define BSA_ASSERT(lbl, prop, msg) \
  `BSA_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/core/bsa_pkg.sv @@
// types and codes of the bitmap slot allocator
package bsa_pkg;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_FULL      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_POOL_BASE  = 1'b0,
    CFG_POOL_READY = 1'b1
  } cfg_reg_e;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned IndexOW = 3;
  localparam int unsigned CountOW = 4;

endpackage

@@ rtl/core/bsa_if.sv @@
// request and response channel interfaces of the slot allocator
interface bsa_req_if import bsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [AddrW-1:0] free_address;

  modport source (output valid, op, free_address, input ready);
  modport sink   (input valid, op, free_address, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [AddrW-1:0]   slot_address;
  logic [IndexOW-1:0] slot_index;
  logic [CountOW-1:0] in_use;
  logic [CountOW-1:0] high_water;

  modport source (output valid, status, slot_address, slot_index, in_use, high_water,
                  input ready);
  modport sink   (input valid, status, slot_address, slot_index, in_use, high_water,
                  output ready);
endinterface

@@ rtl/core/bsa_find_free.sv @@
// lowest free slot search over the occupancy bitmap
module bsa_find_free #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned IDX_W = 3
) (
  input  logic [SLOTS-1:0] map_i,
  output logic             found_o,
  output logic [IDX_W-1:0] index_o
);

  logic [SLOTS-1:0] lowest_zero;

  // isolate lowest clear bit
  assign lowest_zero = ~map_i & (map_i + SLOTS'(1));
  assign found_o     = |(~map_i);

  always_comb begin
    index_o = '0;
    for (int k = 0; k < SLOTS; k++) begin
      index_o = index_o | (lowest_zero[k] ? IDX_W'(k) : '0);
    end
  end

endmodule

@@ rtl/core/bsa_range_chk.sv @@
// pool bounds check and slot index of a free address
module bsa_range_chk import bsa_pkg::*; #(
  parameter int unsigned SLOTS          = 8,
  parameter int unsigned SLOT_SIZE_LOG2 = 13,
  parameter int unsigned IDX_W          = 3
) (
  input  logic [AddrW-1:0] base_i,
  input  logic [AddrW-1:0] addr_i,
  output logic             in_range_o,
  output logic [IDX_W-1:0] index_o
);

  localparam logic [AddrW:0] PoolSpan = (AddrW+1)'(SLOTS) << SLOT_SIZE_LOG2;

  logic [AddrW:0]   pool_end;
  logic [AddrW-1:0] offset;

  // end is exclusive and computed without wrap
  assign pool_end   = {1'b0, base_i} + PoolSpan;
  assign in_range_o = (addr_i >= base_i) && ({1'b0, addr_i} < pool_end);
  assign offset     = addr_i - base_i;
  assign index_o    = offset[SLOT_SIZE_LOG2 +: IDX_W];

endmodule

@@ rtl/core/bitmap_slot_allocator.sv @@
// bitmap slot allocator top level: input register, decision logic, result register
// a request beat passes the input register and then the result register before its response beat is valid
// throughput: one request per cycle while the response is not stalled, set by the bitmap and counter update
// a stalled response holds the input register, so ready falls only under back-pressure
// reset: asynchronous active low; bitmap, counts, pool_base and pool_ready clear to zero
// reset needs no clearing pass; the block takes requests straight out of reset
`include "assert_macros.svh"

module bitmap_slot_allocator import bsa_pkg::*; #(
  parameter int unsigned SLOTS          = 8,
  parameter int unsigned SLOT_SIZE_LOG2 = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bsa_req_if.sink          req_i,
  bsa_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [AddrW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  // configuration registers
  logic [AddrW-1:0] pool_base_q;
  logic             pool_ready_q;

  // allocator state
  logic [SLOTS-1:0] map_q, map_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [CntW-1:0]  peak_q, peak_d;

  // input register
  logic             in_valid_q;
  logic             in_op_q;
  logic [AddrW-1:0] in_addr_q;

  // result register
  logic               out_valid_q;
  logic [2:0]         out_status_q, out_status_d;
  logic [AddrW-1:0]   out_addr_q, out_addr_d;
  logic [IndexOW-1:0] out_index_q, out_index_d;
  logic [CountOW-1:0] out_used_q, out_used_d;
  logic [CountOW-1:0] out_peak_q, out_peak_d;

  logic advance;   // result register can take a new beat
  logic fire;      // registered request is decided this cycle
  logic req_take;

  logic            free_found;
  logic [IdxW-1:0] free_index;
  logic            in_range;
  logic [IdxW-1:0] range_index;

  logic [IdxW-1:0]  act_index;
  logic [AddrW-1:0] slot_offset;
  logic [CntW-1:0]  used_inc;

  // widening helpers for the fixed-width response fields
  logic [IdxW+IndexOW-1:0] index_wide;
  logic [CntW+CountOW-1:0] used_wide;
  logic [CntW+CountOW-1:0] peak_wide;

  //--------------------------------------------------------------------------
  // configuration port
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_ready_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POOL_BASE:  pool_base_q  <= cfg_wdata_i;
        CFG_POOL_READY: pool_ready_q <= cfg_wdata_i[0];
        default:        pool_base_q  <= pool_base_q;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // handshake and input register
  //--------------------------------------------------------------------------
  assign advance     = !out_valid_q || rsp_o.ready;
  assign fire        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;
  assign req_take    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      in_op_q   <= req_i.op;
      in_addr_q <= req_i.free_address;
    end
  end

  //--------------------------------------------------------------------------
  // decision logic
  //--------------------------------------------------------------------------
  bsa_find_free #(
    .SLOTS (SLOTS),
    .IDX_W (IdxW)
  ) u_find_free (
    .map_i   (map_q),
    .found_o (free_found),
    .index_o (free_index)
  );

  bsa_range_chk #(
    .SLOTS          (SLOTS),
    .SLOT_SIZE_LOG2 (SLOT_SIZE_LOG2),
    .IDX_W          (IdxW)
  ) u_range_chk (
    .base_i     (pool_base_q),
    .addr_i     (in_addr_q),
    .in_range_o (in_range),
    .index_o    (range_index)
  );

  assign act_index   = (in_op_q == OP_FREE) ? range_index : free_index;
  assign slot_offset = AddrW'(act_index) << SLOT_SIZE_LOG2;
  assign used_inc    = used_q + CntW'(1);

  always_comb begin
    map_d        = map_q;
    used_d       = used_q;
    peak_d       = peak_q;
    out_status_d = ST_OK;
    out_addr_d   = '0;
    index_wide   = '0;

    if (!pool_ready_q) begin
      out_status_d = ST_NOT_READY;
    end else if (in_op_q == OP_ALLOC) begin
      if (used_q >= CntW'(SLOTS) || !free_found) begin
        out_status_d = ST_FULL;
      end else begin
        map_d      = map_q | (SLOTS'(1) << free_index);
        used_d     = used_inc;
        peak_d     = (used_inc > peak_q) ? used_inc : peak_q;
        out_addr_d = pool_base_q + slot_offset;
        index_wide = {{IndexOW{1'b0}}, act_index};
      end
    end else begin
      if (!in_range) begin
        out_status_d = ST_RANGE;
      end else if (!map_q[range_index]) begin
        out_status_d = ST_NOT_ALLOC;
      end else begin
        map_d      = map_q & ~(SLOTS'(1) << range_index);
        used_d     = used_q - CntW'(1);
        out_addr_d = pool_base_q + slot_offset;
        index_wide = {{IndexOW{1'b0}}, act_index};
      end
    end
  end

  // response fields carry only the low bits of index and counts
  assign used_wide   = {{CountOW{1'b0}}, used_d};
  assign peak_wide   = {{CountOW{1'b0}}, peak_d};
  assign out_index_d = index_wide[IndexOW-1:0];
  assign out_used_d  = used_wide[CountOW-1:0];
  assign out_peak_d  = peak_wide[CountOW-1:0];

  //--------------------------------------------------------------------------
  // state and result register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q       <= '0;
      used_q      <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        map_q  <= map_d;
        used_q <= used_d;
        peak_q <= peak_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= out_status_d;
      out_addr_q   <= out_addr_d;
      out_index_q  <= out_index_d;
      out_used_q   <= out_used_d;
      out_peak_q   <= out_peak_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.slot_address = out_addr_q;
  assign rsp_o.slot_index   = out_index_q;
  assign rsp_o.in_use       = out_used_q;
  assign rsp_o.high_water   = out_peak_q;

  //--------------------------------------------------------------------------
  // assertions
  //--------------------------------------------------------------------------
  `BSA_ASSERT(a_map_matches_count, ($countones(map_q) == int'(used_q)), "bitmap and count disagree")
  `BSA_ASSERT(a_peak_covers_used, (peak_q >= used_q), "high-water mark below in-use count")
  `BSA_ASSERT(a_used_bounded, (used_q <= CntW'(SLOTS)), "in-use count exceeds pool")
  `BSA_ASSERT(a_fail_zero_fields, (out_valid_q && out_status_q != ST_OK |-> out_addr_q == '0 && out_index_q == '0), "failed beat carries a slot")

endmodule
